// ----- design/assert_macros.svh -----
// assertion helpers, clocked on clk and quiet while rst is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, expr)
`define ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- design/dpd_pkg.sv -----
package dpd_pkg;

  localparam int BUFFER_BYTES = 8192;
  localparam int LEN_W = 13;
  localparam logic [LEN_W-1:0] LIMIT_CAP = LEN_W'(BUFFER_BYTES - 1);

  localparam logic [7:0] CH_START = 8'h24;  // '$'
  localparam logic [7:0] CH_HASH  = 8'h23;  // '#'
  localparam logic [7:0] CH_BREAK = 8'h03;

  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_DATA = 2'd1;
  localparam logic [1:0] PH_DIG1 = 2'd2;
  localparam logic [1:0] PH_DIG2 = 2'd3;

  localparam logic [1:0] K_PAYLOAD = 2'd0;
  localparam logic [1:0] K_GOOD    = 2'd1;
  localparam logic [1:0] K_BAD     = 2'd2;
  localparam logic [1:0] K_BREAK   = 2'd3;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       payload_byte;
    logic [LEN_W-1:0] payload_len;
    logic [7:0]       sum_received;
    logic [7:0]       sum_computed;
  } res_t;

  // {valid, nibble}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

// ----- design/dpd_frame_fsm.sv -----
module dpd_frame_fsm (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    step,
  input  logic [7:0]              byte_in,
  input  logic [dpd_pkg::LEN_W-1:0] limit,
  output logic                    res_valid,
  output dpd_pkg::res_t           res
);
  import dpd_pkg::*;

  logic [1:0]       phase, phase_next;
  logic [7:0]       running_sum, running_sum_next;
  logic [LEN_W-1:0] byte_count, byte_count_next;
  logic [3:0]       first_digit, first_digit_next;
  logic             first_digit_valid, first_digit_valid_next;
  logic [LEN_W-1:0] eff_limit;
  logic [4:0]       hex;
  logic [7:0]       rx_sum;

  assign eff_limit = (limit < LIMIT_CAP) ? limit : LIMIT_CAP;
  assign hex = hex_decode(byte_in);

  always_comb begin
    phase_next = phase;
    running_sum_next = running_sum;
    byte_count_next = byte_count;
    first_digit_next = first_digit;
    first_digit_valid_next = first_digit_valid;
    res_valid = 1'b0;
    res = '0;
    rx_sum = 8'd0;
    unique case (phase)
      PH_HUNT: begin
        if (byte_in == CH_START) begin
          phase_next = PH_DATA;
          running_sum_next = 8'd0;
          byte_count_next = '0;
        end else if (byte_in == CH_BREAK) begin
          res_valid = 1'b1;
          res.kind = K_BREAK;
        end
      end
      PH_DATA: begin
        if (byte_count >= eff_limit) begin
          // length cutoff: this byte is already the first digit
          first_digit_next = hex[4] ? hex[3:0] : 4'd0;
          first_digit_valid_next = hex[4];
          phase_next = PH_DIG2;
        end else if (byte_in == CH_HASH) begin
          phase_next = PH_DIG1;
        end else begin
          running_sum_next = running_sum + byte_in;
          byte_count_next = byte_count + LEN_W'(1);
          res_valid = 1'b1;
          res.kind = K_PAYLOAD;
          res.payload_byte = byte_in;
        end
      end
      PH_DIG1: begin
        first_digit_next = hex[4] ? hex[3:0] : 4'd0;
        first_digit_valid_next = hex[4];
        phase_next = PH_DIG2;
      end
      PH_DIG2: begin
        if (first_digit_valid) begin
          rx_sum = hex[4] ? {first_digit, hex[3:0]} : {4'd0, first_digit};
        end
        res_valid = 1'b1;
        res.kind = (rx_sum == running_sum) ? K_GOOD : K_BAD;
        res.payload_len = byte_count;
        res.sum_received = rx_sum;
        res.sum_computed = running_sum;
        phase_next = PH_HUNT;
        running_sum_next = 8'd0;
        byte_count_next = '0;
        first_digit_next = 4'd0;
        first_digit_valid_next = 1'b0;
      end
      default: begin
        phase_next = PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT;
      running_sum <= 8'd0;
      byte_count <= '0;
      first_digit <= 4'd0;
      first_digit_valid <= 1'b0;
    end else if (step) begin
      phase <= phase_next;
      running_sum <= running_sum_next;
      byte_count <= byte_count_next;
      first_digit <= first_digit_next;
      first_digit_valid <= first_digit_valid_next;
    end
  end

endmodule

// ----- design/dpd_out_reg.sv -----
module dpd_out_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  dpd_pkg::res_t res,
  input  logic          out_stall,
  output logic          out_free,
  output logic          out_valid,
  output dpd_pkg::res_t out_res
);
  import dpd_pkg::*;

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && load) begin
      out_res <= res;
    end
  end

endmodule

// ----- design/debug_packet_deframer.sv -----
// channel   direction  handshake               payload
// in        in         in_valid / in_stall     rx_byte
// out       out        out_valid / out_stall   kind, payload_byte, payload_len,
//                                              sum_received, sum_computed
// cfg       in         cfg_valid / cfg_ready   cfg_data (max_payload_len)
//
// one byte per cycle while out_stall is low; a taken byte is loaded into the input
// register, then the frame state steps on it and loads any result into the
// result register, once the result register is free to move
// rst is synchronous: frame state back to hunting, limit back to 8191
// out_stall holds the result register; the input register still takes a byte
// while it is empty, so in_stall rises only when both stages are occupied
module debug_packet_deframer (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                rx_byte,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                kind,
  output logic [7:0]                payload_byte,
  output logic [dpd_pkg::LEN_W-1:0] payload_len,
  output logic [7:0]                sum_received,
  output logic [7:0]                sum_computed,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [dpd_pkg::LEN_W-1:0] cfg_data
);
  import dpd_pkg::*;

  `include "assert_macros.svh"

  logic             s1_valid;
  logic [7:0]       s1_byte;
  logic [LEN_W-1:0] max_payload_len;
  logic             out_free;
  logic             step;
  logic             res_valid;
  res_t             res;
  res_t             out_res;

  // config register, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload_len <= LEN_W'(8191);
    end else if (cfg_valid && cfg_ready) begin
      max_payload_len <= cfg_data;
    end
  end

  // input register: stalls only when full and the result side cannot move
  assign in_stall = s1_valid && !out_free;
  assign step = s1_valid && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_byte <= rx_byte;
    end
  end

  // frame state machine, one step per registered byte
  dpd_frame_fsm u_fsm (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .byte_in   (s1_byte),
    .limit     (max_payload_len),
    .res_valid (res_valid),
    .res       (res)
  );

  // result register; bytes that give no result simply leave it empty
  dpd_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (step && res_valid),
    .res       (res),
    .out_stall (out_stall),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign kind         = out_res.kind;
  assign payload_byte = out_res.payload_byte;
  assign payload_len  = out_res.payload_len;
  assign sum_received = out_res.sum_received;
  assign sum_computed = out_res.sum_computed;

  // a taken byte always lands in the input register
  `ASSERT_NEXT(a_take_lands, in_valid && !in_stall, s1_valid)
  // good verdict only when the two sums agree
  `ASSERT_ALWAYS(a_good_sums, !(out_valid && kind == K_GOOD) || sum_received == sum_computed)
  // bad verdict only when they differ
  `ASSERT_ALWAYS(a_bad_sums, !(out_valid && kind == K_BAD) || sum_received != sum_computed)
  // payload byte field is zero outside payload transactions
  `ASSERT_ALWAYS(a_byte_zero, !(out_valid && kind != K_PAYLOAD) || payload_byte == 8'd0)

endmodule

// ----- tb/debug_packet_deframer_tb.sv -----
module debug_packet_deframer_tb;
  import dpd_pkg::*;

  // expected-result tracker: follows the framing state byte by byte and
  // holds the results the block still owes
  class packet_tracker;
    logic [LEN_W-1:0] limit;
    logic [1:0]       phase;
    logic [7:0]       sum;
    logic [LEN_W-1:0] count;
    logic [3:0]       hi_nibble;
    bit               hi_ok;
    res_t             pending[$];
    int               errors;
    int               n_good;
    int               n_bad;
    int               n_break;
    int               n_payload;

    function new();
      limit = LEN_W'(8191);
      phase = PH_HUNT;
      sum = '0;
      count = '0;
      hi_nibble = '0;
      hi_ok = 1'b0;
      errors = 0;
      n_good = 0;
      n_bad = 0;
      n_break = 0;
      n_payload = 0;
    endfunction

    function void set_limit(input logic [LEN_W-1:0] v);
      limit = v;
    endfunction

    function bit is_hex(input logic [7:0] c, output logic [3:0] v);
      v = '0;
      if (c inside {[8'h30:8'h39]}) v = c[3:0];
      else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) v = c[3:0] + 4'd9;
      else return 1'b0;
      return 1'b1;
    endfunction

    function void take_digit(input logic [7:0] c);
      hi_ok = is_hex(c, hi_nibble);
      phase = PH_DIG2;
    endfunction

    function void take_byte(input logic [7:0] c);
      res_t       r;
      logic [3:0] lo;
      logic [7:0] rx;
      r = '0;
      case (phase)
        PH_HUNT: begin
          if (c == CH_START) begin
            phase = PH_DATA;
            sum = '0;
            count = '0;
          end else if (c == CH_BREAK) begin
            r.kind = K_BREAK;
            pending.push_back(r);
          end
        end
        PH_DATA: begin
          if (count >= ((limit < LIMIT_CAP) ? limit : LIMIT_CAP)) begin
            take_digit(c);
          end else if (c == CH_HASH) begin
            phase = PH_DIG1;
          end else begin
            sum = sum + c;
            count = count + LEN_W'(1);
            r.kind = K_PAYLOAD;
            r.payload_byte = c;
            pending.push_back(r);
          end
        end
        PH_DIG1: take_digit(c);
        default: begin
          // second digit closes the packet; a bad first digit zeroes the value
          rx = '0;
          if (hi_ok) begin
            rx = {4'd0, hi_nibble};
            if (is_hex(c, lo)) rx = {hi_nibble, lo};
          end
          r.kind = (rx == sum) ? K_GOOD : K_BAD;
          r.payload_len = count;
          r.sum_received = rx;
          r.sum_computed = sum;
          pending.push_back(r);
          phase = PH_HUNT;
          sum = '0;
          count = '0;
          hi_nibble = '0;
          hi_ok = 1'b0;
        end
      endcase
    endfunction

    function void compare_field(input string name, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_output(input res_t got);
      res_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, expected none actual kind %0d",
                 $time, got.kind);
        return;
      end
      want = pending.pop_front();
      compare_field("kind", want.kind, got.kind);
      compare_field("payload_byte", want.payload_byte, got.payload_byte);
      compare_field("payload_len", want.payload_len, got.payload_len);
      compare_field("sum_received", want.sum_received, got.sum_received);
      compare_field("sum_computed", want.sum_computed, got.sum_computed);
      case (want.kind)
        K_GOOD: n_good++;
        K_BAD: n_bad++;
        K_BREAK: n_break++;
        default: n_payload++;
      endcase
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_stall;
  logic [7:0]       rx_byte;
  logic             out_valid;
  logic             out_stall;
  logic [1:0]       kind;
  logic [7:0]       payload_byte;
  logic [LEN_W-1:0] payload_len;
  logic [7:0]       sum_received;
  logic [7:0]       sum_computed;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [LEN_W-1:0] cfg_data;

  packet_tracker tracker = new();

  logic [7:0] stream[$];   // bytes queued for the next send
  int         cur_limit;   // limit the block holds right now
  int         gap_pct;     // chance per byte of an input gap burst
  int         stall_pct;   // chance per cycle of an output stall burst
  int         stall_left;
  int         bytes_sent;

  debug_packet_deframer uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .payload_byte (payload_byte),
    .payload_len  (payload_len),
    .sum_received (sum_received),
    .sum_computed (sum_computed),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #3000000;
    $display("timeout with %0d results outstanding", tracker.pending.size());
    $display("debug_packet_deframer: mismatch");
    $finish;
  end

  // output side: random stall bursts, changed at the falling edge
  initial begin
    out_stall = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_pct == 0) begin
        stall_left = 0;
      end else if (stall_left > 0) begin
        stall_left--;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(1, 18);
      end
      out_stall <= (stall_left > 0);
    end
  end

  // every accepted output transaction is checked against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      tracker.check_output('{kind, payload_byte, payload_len, sum_received, sum_computed});
    end
  end

  // one input transaction; entered and left at a falling edge
  task automatic push_byte(input logic [7:0] b);
    if ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.take_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_stream();
    foreach (stream[i]) push_byte(stream[i]);
    in_valid <= 1'b0;
    stream.delete();
  endtask

  // waits until every expected result is out, then for the pipeline to empty
  task automatic drain();
    while (tracker.pending.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_limit(input int v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= LEN_W'(v);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.set_limit(LEN_W'(v));
    cur_limit = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + n;
    return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + n - 8'd10;
  endfunction

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) stream.push_back(s[i]);
  endtask

  // one packet (sometimes cut off at the limit), a break byte, or line noise
  task automatic add_packet(input int max_len);
    int         pick;
    int         len;
    bit         cutoff;
    logic [7:0] b;
    logic [7:0] total;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      repeat ($urandom_range(1, 4)) stream.push_back(8'($urandom_range(0, 255)));
    end else if (pick < 13) begin
      stream.push_back(CH_BREAK);
    end else begin
      total = '0;
      cutoff = (pick < 28 || cur_limit == 0) && cur_limit <= max_len;
      if (cutoff) len = cur_limit;
      else len = $urandom_range(0, (cur_limit - 1 < max_len) ? cur_limit - 1 : max_len);
      stream.push_back(CH_START);
      repeat (len) begin
        b = 8'($urandom_range(0, 255));
        if (b == CH_HASH) b = 8'h2a;
        total += b;
        stream.push_back(b);
      end
      if (!cutoff) stream.push_back(CH_HASH);
      if ($urandom_range(0, 4) != 0) begin
        stream.push_back(hex_char(total[7:4]));
        stream.push_back(hex_char(total[3:0]));
      end else begin
        // corrupted checksum: wrong hex digits or arbitrary bytes
        repeat (2) begin
          if ($urandom_range(0, 1)) stream.push_back(hex_char(4'($urandom_range(0, 15))));
          else stream.push_back(8'($urandom_range(0, 255)));
        end
      end
    end
  endtask

  task automatic random_traffic(input int n_bytes, input int max_len);
    while (stream.size() < n_bytes) add_packet(max_len);
    send_stream();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    rx_byte = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    cur_limit = 8191;
    gap_pct = 15;
    stall_pct = 10;
    bytes_sent = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: break, ignored bytes, empty packet, special bytes in payload,
    // bad first digit, hex then non-hex second digit, upper case digits
    stream.push_back(CH_BREAK);
    stream.push_back(8'h00);
    stream.push_back(8'hff);
    add_text("x$#00");
    stream.push_back(CH_START);
    stream.push_back(8'h00);
    stream.push_back(8'hff);
    stream.push_back(CH_START);
    stream.push_back(CH_BREAK);
    add_text("#26$a#zz$ab#C3$#5g");
    send_stream();

    // limit lowered while a packet is open: the count is already past it
    add_text("$abcd");
    send_stream();
    write_limit(2);
    add_text("xy");
    send_stream();

    // zero limit: the byte after the start is already a checksum digit
    write_limit(0);
    add_text("$00$#1");
    send_stream();

    // limit of one: a hash after the cutoff is taken as a digit
    write_limit(1);
    add_text("$a#1$a61");
    send_stream();

    // random phases over several limits and idling mixes
    write_limit(8191);
    random_traffic(70, 12);
    write_limit(3);
    random_traffic(70, 8);
    write_limit(1);
    gap_pct = 0;
    stall_pct = 30;
    random_traffic(60, 4);
    write_limit(0);
    gap_pct = 25;
    stall_pct = 5;
    random_traffic(50, 4);
    write_limit($urandom_range(2, 24));
    gap_pct = 10;
    stall_pct = 10;
    random_traffic(70, 30);
    write_limit($urandom_range(4, 12));
    random_traffic(60, 16);

    // last stretch runs flat out on both sides
    gap_pct = 0;
    stall_pct = 0;
    write_limit($urandom_range(1, 16));
    random_traffic(90, 20);

    drain();
    if (tracker.pending.size() != 0) tracker.errors++;
    $display("%0d bytes sent over limits 0 to 8191, with and without idling", bytes_sent);
    $display("checked %0d payload bytes, %0d good and %0d bad packets, %0d breaks",
             tracker.n_payload, tracker.n_good, tracker.n_bad, tracker.n_break);
    if (tracker.errors == 0) begin
      $display("debug_packet_deframer: match");
    end else begin
      $display("debug_packet_deframer: mismatch");
    end
    $finish;
  end

endmodule
